// ===== src/btss_pkg.sv =====
// btss_pkg: shared widths, event and packet codes, register indexes and the
// command/status structs between the sequencer controller and its datapath.
// No dependencies.
package btss_pkg;

    // field widths
    localparam int CFG_W     = 32;
    localparam int CFG_IDX_W = 2;
    localparam int KIND_W    = 3;
    localparam int STAT_W    = 8;
    localparam int RPP_W     = 16;
    localparam int APPB_W    = 16;
    localparam int PPB_W     = 6;
    localparam int RPB_W     = RPP_W + PPB_W;
    localparam int REC_W     = 32;
    localparam int BLAST_W   = 32;
    localparam int MAP_W     = 32;
    localparam int PIDX_W    = 5;
    localparam int LOOP_W    = 6;
    localparam int HR_W      = 3;
    localparam int RT_W      = 4;
    localparam int DIVN_W    = REC_W + 1;
    localparam int START_W   = BLAST_W + RPB_W;

    // parameter defaults
    localparam int BLAST_PKT_MAX_DEF = 32;
    localparam int DEFAULT_RPP_DEF   = 16;
    localparam int RETRY_LIMIT_DEF   = 5;

    // disconnects sent at the end of the transfer
    localparam int FIN_COUNT = 5;

    // event kinds
    localparam logic [KIND_W-1:0] EV_START   = 3'd0;
    localparam logic [KIND_W-1:0] EV_TIMEOUT = 3'd1;
    localparam logic [KIND_W-1:0] EV_HDR_ACK = 3'd2;
    localparam logic [KIND_W-1:0] EV_MISSING = 3'd3;
    localparam logic [KIND_W-1:0] EV_OTHER   = 3'd4;

    // packet kinds
    localparam logic [KIND_W-1:0] PK_HEADER     = 3'd0;
    localparam logic [KIND_W-1:0] PK_BLAST      = 3'd1;
    localparam logic [KIND_W-1:0] PK_BLAST_OVER = 3'd2;
    localparam logic [KIND_W-1:0] PK_DISCONNECT = 3'd3;
    localparam logic [KIND_W-1:0] PK_ABORT      = 3'd4;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TOTAL_RECORDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_RPP      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_PPB      = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic              load_in;
        logic              init_sizing;
        logic              adjust_sizing;
        logic              calc_rpb;
        logic              div_total;
        logic              latch_bt;
        logic              calc_start;
        logic              calc_ric;
        logic              div_pkts;
        logic              latch_pcb;
        logic              inc_cb;
        logic              idx_clr;
        logic              idx_inc;
        logic              emit;
        logic [KIND_W-1:0] emit_kind;
        logic              emit_last;
    } ctrl_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              status_nz;
        logic              mcount_zero;
        logic              cb_invalid;
        logic              cb_ge_bt;
        logic              start_past_end;
        logic              div_busy;
        logic              idx_lt_pcb;
        logic              idx_lt_bound;
        logic              fin_last;
        logic              map_bit;
        logic              map_last;
        logic              out_free;
    } dp_status_t;

endpackage

// ===== src/btss_div.sv =====
// btss_div: restoring divider, one quotient bit per cycle.
// Depends on nothing; widths come from its parameters.
module btss_div #(
    parameter int N_W = 33,
    parameter int D_W = 22
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           start,
    input  logic [N_W-1:0] dividend,
    input  logic [D_W-1:0] divisor,
    output logic           busy,
    output logic [N_W-1:0] quotient
);
    localparam int CNT_W = $clog2(N_W + 1);

    logic             busy_reg, busy_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [D_W-1:0]   rem_reg, rem_next;
    logic [N_W-1:0]   quo_reg, quo_next;
    logic [D_W-1:0]   dsr_reg, dsr_next;
    logic [D_W:0]     shifted;
    logic [D_W:0]     diff;

    // one trial subtraction per cycle
    always_comb begin
        shifted   = {rem_reg, quo_reg[N_W-1]};
        diff      = shifted - {1'b0, dsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(N_W);
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            if (!diff[D_W]) begin
                rem_next = diff[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[D_W-1:0];
                quo_next = {quo_reg[N_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

// ===== src/btss_datapath.sv =====
// btss_datapath: configuration, sizing, blast bookkeeping, shared divider and
// the result output register. Depends on btss_pkg and btss_div.
module btss_datapath #(
    parameter int BLAST_PKT_MAX = btss_pkg::BLAST_PKT_MAX_DEF,
    parameter int DEFAULT_RPP   = btss_pkg::DEFAULT_RPP_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [btss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btss_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic [btss_pkg::KIND_W-1:0]     s_kind,
    input  logic [btss_pkg::STAT_W-1:0]     s_ack_status,
    input  logic [btss_pkg::RPP_W-1:0]      s_ack_records_per_packet,
    input  logic [btss_pkg::APPB_W-1:0]     s_ack_packets_per_blast,
    input  logic [btss_pkg::REC_W-1:0]      s_missing_count,
    input  logic [btss_pkg::MAP_W-1:0]      s_missing_map,
    input  btss_pkg::ctrl_cmd_t             cmd,
    output btss_pkg::dp_status_t            status,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [btss_pkg::KIND_W-1:0]     m_packet_kind,
    output logic [btss_pkg::BLAST_W-1:0]    m_blast_number,
    output logic [btss_pkg::PIDX_W-1:0]     m_packet_index,
    output logic [btss_pkg::PPB_W-1:0]      m_packets_this_blast,
    output logic [btss_pkg::REC_W-1:0]      m_first_record,
    output logic [btss_pkg::RPP_W-1:0]      m_record_count,
    output logic                            m_last_of_run
);
    localparam int RPP_W   = btss_pkg::RPP_W;
    localparam int PPB_W   = btss_pkg::PPB_W;
    localparam int RPB_W   = btss_pkg::RPB_W;
    localparam int REC_W   = btss_pkg::REC_W;
    localparam int MAP_W   = btss_pkg::MAP_W;
    localparam int LOOP_W  = btss_pkg::LOOP_W;
    localparam int START_W = btss_pkg::START_W;
    localparam int DIVN_W  = btss_pkg::DIVN_W;
    localparam logic [PPB_W-1:0] MAX_PPB = PPB_W'(BLAST_PKT_MAX);

    // configuration registers
    logic [REC_W-1:0] total_reg;
    logic [RPP_W-1:0] init_rpp_reg;
    logic [PPB_W-1:0] init_ppb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg    <= REC_W'(1);
            init_rpp_reg <= '0;
            init_ppb_reg <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                btss_pkg::CFG_TOTAL_RECORDS: total_reg    <= cfg_wr_data;
                btss_pkg::CFG_INIT_RPP:      init_rpp_reg <= cfg_wr_data[RPP_W-1:0];
                btss_pkg::CFG_INIT_PPB:      init_ppb_reg <= cfg_wr_data[PPB_W-1:0];
                default: ;
            endcase
        end
    end

    // latched transaction
    logic [btss_pkg::KIND_W-1:0] kind_reg;
    logic                        stat_nz_reg;
    logic [RPP_W-1:0]            arpp_reg;
    logic [btss_pkg::APPB_W-1:0] appb_reg;
    logic                        mzero_reg;
    logic [MAP_W-1:0]            map_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            kind_reg    <= s_kind;
            stat_nz_reg <= (s_ack_status != '0);
            arpp_reg    <= s_ack_records_per_packet;
            appb_reg    <= s_ack_packets_per_blast;
            mzero_reg   <= (s_missing_count == '0);
            map_reg     <= s_missing_map;
        end
    end

    // sizing and blast state
    logic [RPP_W-1:0]             rpp_reg;
    logic [PPB_W-1:0]             ppb_reg;
    logic [RPB_W-1:0]             rpb_reg;
    logic [btss_pkg::BLAST_W-1:0] bt_reg;
    logic [btss_pkg::BLAST_W-1:0] cb_reg;
    logic [PPB_W-1:0]             pcb_reg;
    logic [RPB_W-1:0]             ric_reg;
    logic [START_W-1:0]           start_reg;
    logic [LOOP_W-1:0]            idx_reg;

    logic [RPP_W-1:0]   rpp_eff;
    logic [RPB_W-1:0]   rpb_prod;
    logic [START_W-1:0] start_prod;
    logic [REC_W-1:0]   remain;
    logic [RPB_W-1:0]   ric_val;
    logic [DIVN_W-1:0]  div_dividend;
    logic [RPB_W-1:0]   div_divisor;
    logic               div_busy;
    logic [DIVN_W-1:0]  div_quo;

    assign rpp_eff    = (rpp_reg == '0) ? RPP_W'(1) : rpp_reg;
    assign rpb_prod   = RPB_W'(rpp_reg) * RPB_W'(ppb_reg);
    assign start_prod = START_W'(cb_reg - 1'b1) * START_W'(rpb_reg);
    assign remain     = total_reg - start_reg[REC_W-1:0];
    assign ric_val    = (remain > REC_W'(rpb_reg)) ? rpb_reg : remain[RPB_W-1:0];

    // one divider serves the blast count and the packet count
    always_comb begin
        if (cmd.div_total) begin
            div_dividend = DIVN_W'(total_reg) + DIVN_W'(rpb_reg) - 1'b1;
            div_divisor  = rpb_reg;
        end else begin
            div_dividend = DIVN_W'(ric_reg) + DIVN_W'(rpp_eff) - 1'b1;
            div_divisor  = RPB_W'(rpp_eff);
        end
    end

    btss_div #(
        .N_W(DIVN_W),
        .D_W(RPB_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_total | cmd.div_pkts),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rpp_reg   <= '0;
            ppb_reg   <= '0;
            rpb_reg   <= '0;
            bt_reg    <= '0;
            cb_reg    <= btss_pkg::BLAST_W'(1);
            pcb_reg   <= '0;
            ric_reg   <= '0;
            start_reg <= '0;
            idx_reg   <= '0;
        end else begin
            if (cmd.init_sizing) begin
                rpp_reg <= (init_rpp_reg == '0) ? RPP_W'(DEFAULT_RPP) : init_rpp_reg;
                if (init_ppb_reg == '0 || init_ppb_reg > MAX_PPB) begin
                    ppb_reg <= MAX_PPB;
                end else begin
                    ppb_reg <= init_ppb_reg;
                end
            end
            if (cmd.adjust_sizing) begin
                if (arpp_reg != '0) begin
                    rpp_reg <= arpp_reg;
                end
                if (appb_reg != '0) begin
                    ppb_reg <= (appb_reg > btss_pkg::APPB_W'(MAX_PPB)) ?
                               MAX_PPB : appb_reg[PPB_W-1:0];
                end
            end
            if (cmd.calc_rpb) begin
                rpb_reg <= (rpb_prod == '0) ? RPB_W'(1) : rpb_prod;
            end
            if (cmd.latch_bt) begin
                bt_reg <= div_quo[btss_pkg::BLAST_W-1:0];
            end
            if (cmd.inc_cb) begin
                cb_reg <= cb_reg + 1'b1;
            end
            if (cmd.calc_start) begin
                start_reg <= start_prod;
            end
            if (cmd.calc_ric) begin
                ric_reg <= ric_val;
            end
            if (cmd.latch_pcb) begin
                pcb_reg <= div_quo[PPB_W-1:0];
            end
            if (cmd.idx_clr) begin
                idx_reg <= '0;
            end else if (cmd.idx_inc) begin
                idx_reg <= idx_reg + 1'b1;
            end
        end
    end

    // blast packet fields for packet idx
    logic [RPB_W-1:0] local_ofs;
    logic [RPB_W-1:0] left;
    logic [RPP_W-1:0] pkt_cnt;
    logic [REC_W-1:0] pkt_first;

    always_comb begin
        local_ofs = RPB_W'(idx_reg) * RPB_W'(rpp_eff);
        left      = ric_reg - local_ofs;
        pkt_cnt   = '0;
        if (local_ofs < ric_reg) begin
            pkt_cnt = (left < RPB_W'(rpp_eff)) ? left[RPP_W-1:0] : rpp_eff;
        end
        pkt_first = start_reg[REC_W-1:0] + REC_W'(local_ofs);
    end

    // missing map limited to the blast size
    logic [MAP_W-1:0]  map_m;
    logic [MAP_W-1:0]  map_hi;
    logic [LOOP_W-1:0] bound;

    always_comb begin
        for (int j = 0; j < MAP_W; j++) begin
            map_m[j] = map_reg[j] & (LOOP_W'(j) < LOOP_W'(ppb_reg));
        end
        map_hi = map_m >> idx_reg;
        bound  = (LOOP_W'(ppb_reg) > LOOP_W'(MAP_W)) ? LOOP_W'(MAP_W) : LOOP_W'(ppb_reg);
    end

    // output register
    logic                          out_valid_reg;
    logic [btss_pkg::KIND_W-1:0]   o_kind_reg;
    logic [btss_pkg::BLAST_W-1:0]  o_bn_reg;
    logic [btss_pkg::PIDX_W-1:0]   o_pidx_reg;
    logic [PPB_W-1:0]              o_pcount_reg;
    logic [REC_W-1:0]              o_first_reg;
    logic [RPP_W-1:0]              o_cnt_reg;
    logic                          o_last_reg;
    logic                          out_free;
    logic                          is_pkt;

    assign out_free = !out_valid_reg || m_ready;
    assign is_pkt   = (cmd.emit_kind == btss_pkg::PK_BLAST);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (cmd.emit) begin
            o_kind_reg   <= cmd.emit_kind;
            o_bn_reg     <= cb_reg;
            o_pidx_reg   <= is_pkt ? idx_reg[btss_pkg::PIDX_W-1:0] : '0;
            o_pcount_reg <= (is_pkt || cmd.emit_kind == btss_pkg::PK_BLAST_OVER) ?
                            pcb_reg : '0;
            o_first_reg  <= is_pkt ? pkt_first : '0;
            o_cnt_reg    <= is_pkt ? pkt_cnt : '0;
            o_last_reg   <= cmd.emit_last;
        end
    end

    assign m_valid              = out_valid_reg;
    assign m_packet_kind        = o_kind_reg;
    assign m_blast_number       = o_bn_reg;
    assign m_packet_index       = o_pidx_reg;
    assign m_packets_this_blast = o_pcount_reg;
    assign m_first_record       = o_first_reg;
    assign m_record_count       = o_cnt_reg;
    assign m_last_of_run        = o_last_reg;

    // status toward the controller
    always_comb begin
        status.kind           = kind_reg;
        status.status_nz      = stat_nz_reg;
        status.mcount_zero    = mzero_reg;
        status.cb_invalid     = (cb_reg == '0) || (cb_reg > bt_reg);
        status.cb_ge_bt       = (cb_reg >= bt_reg);
        status.start_past_end = (start_reg >= START_W'(total_reg));
        status.div_busy       = div_busy;
        status.idx_lt_pcb     = (idx_reg < LOOP_W'(pcb_reg));
        status.idx_lt_bound   = (idx_reg < bound);
        status.fin_last       = (idx_reg == LOOP_W'(btss_pkg::FIN_COUNT - 1));
        status.map_bit        = map_hi[0];
        status.map_last       = (map_hi[MAP_W-1:1] == '0);
        status.out_free       = out_free;
    end
endmodule

// ===== src/btss_ctrl.sv =====
// btss_ctrl: sequencer state machine; holds the transfer phase and retry
// counters and drives the datapath commands. Depends on btss_pkg.
module btss_ctrl #(
    parameter int RETRY_LIMIT = btss_pkg::RETRY_LIMIT_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  btss_pkg::dp_status_t status,
    output btss_pkg::ctrl_cmd_t  cmd
);
    typedef enum logic [15:0] {
        ST_IDLE     = 16'h0001,
        ST_DISPATCH = 16'h0002,
        ST_RPB      = 16'h0004,
        ST_DIVT     = 16'h0008,
        ST_DIVT_W   = 16'h0010,
        ST_HDR_OUT  = 16'h0020,
        ST_HTO      = 16'h0040,
        ST_ABORT    = 16'h0080,
        ST_WTO      = 16'h0100,
        ST_SB_CHK0  = 16'h0200,
        ST_SB_CHK   = 16'h0400,
        ST_SB_DIV   = 16'h0800,
        ST_SB_DIVW  = 16'h1000,
        ST_SB_PKT   = 16'h2000,
        ST_FIN      = 16'h4000,
        ST_RESEND   = 16'h8000
    } state_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_HDR  = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    localparam int HR_W = btss_pkg::HR_W;
    localparam int RT_W = btss_pkg::RT_W;

    state_t            state_reg, state_next;
    phase_t            phase_reg, phase_next;
    logic [HR_W-1:0]   hr_reg, hr_next;
    logic [RT_W-1:0]   rt_reg, rt_next;
    logic              from_start_reg, from_start_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        hr_next         = hr_reg;
        rt_next         = rt_reg;
        from_start_next = from_start_reg;
        cmd             = '0;
        cmd.emit_kind   = btss_pkg::PK_HEADER;

        case (state_reg)
            // wait for an event
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_DISPATCH;
                end
            end

            // decode event against phase
            ST_DISPATCH: begin
                cmd.idx_clr = 1'b1;
                state_next  = ST_IDLE;
                case (phase_reg)
                    PH_IDLE: begin
                        if (status.kind == btss_pkg::EV_START) begin
                            cmd.init_sizing = 1'b1;
                            hr_next         = HR_W'(RETRY_LIMIT);
                            from_start_next = 1'b1;
                            state_next      = ST_RPB;
                        end
                    end
                    PH_HDR: begin
                        if (status.kind == btss_pkg::EV_TIMEOUT) begin
                            if (hr_reg != '0) begin
                                hr_next = hr_reg - 1'b1;
                            end
                            state_next = ST_HTO;
                        end else if (status.kind == btss_pkg::EV_HDR_ACK) begin
                            rt_next = '0;
                            if (status.status_nz) begin
                                cmd.adjust_sizing = 1'b1;
                                from_start_next   = 1'b0;
                                state_next        = ST_RPB;
                            end else begin
                                state_next = ST_SB_CHK0;
                            end
                        end
                    end
                    PH_WAIT: begin
                        if (status.kind == btss_pkg::EV_TIMEOUT) begin
                            rt_next    = rt_reg + 1'b1;
                            state_next = ST_WTO;
                        end else if (status.kind == btss_pkg::EV_HDR_ACK ||
                                     status.kind == btss_pkg::EV_MISSING ||
                                     status.kind == btss_pkg::EV_OTHER) begin
                            rt_next = '0;
                            if (status.kind == btss_pkg::EV_MISSING) begin
                                if (!status.mcount_zero) begin
                                    state_next = ST_RESEND;
                                end else if (status.cb_ge_bt) begin
                                    state_next = ST_FIN;
                                end else begin
                                    cmd.inc_cb = 1'b1;
                                    state_next = ST_SB_CHK0;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end

            // records per blast, then blast count
            ST_RPB: begin
                cmd.calc_rpb = 1'b1;
                state_next   = ST_DIVT;
            end
            ST_DIVT: begin
                cmd.div_total = 1'b1;
                state_next    = ST_DIVT_W;
            end
            ST_DIVT_W: begin
                if (!status.div_busy) begin
                    cmd.latch_bt = 1'b1;
                    state_next   = from_start_reg ? ST_HDR_OUT : ST_SB_CHK0;
                end
            end

            // header after start
            ST_HDR_OUT: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = btss_pkg::PK_HEADER;
                    cmd.emit_last = 1'b1;
                    phase_next    = PH_HDR;
                    state_next    = ST_IDLE;
                end
            end

            // header resend, abort when retries are used up
            ST_HTO: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = btss_pkg::PK_HEADER;
                    cmd.emit_last = (hr_reg != '0);
                    state_next    = (hr_reg == '0) ? ST_ABORT : ST_IDLE;
                end
            end

            ST_ABORT: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = btss_pkg::PK_ABORT;
                    cmd.emit_last = 1'b1;
                    phase_next    = PH_DONE;
                    state_next    = ST_IDLE;
                end
            end

            // report timeout: blast-over again or abort
            ST_WTO: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_last = 1'b1;
                    state_next    = ST_IDLE;
                    if (rt_reg > RT_W'(RETRY_LIMIT)) begin
                        cmd.emit_kind = btss_pkg::PK_ABORT;
                        phase_next    = PH_DONE;
                    end else begin
                        cmd.emit_kind = btss_pkg::PK_BLAST_OVER;
                    end
                end
            end

            // send blast: range checks and packet count
            ST_SB_CHK0: begin
                if (status.cb_invalid) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.calc_start = 1'b1;
                    state_next     = ST_SB_CHK;
                end
            end
            ST_SB_CHK: begin
                if (status.start_past_end) begin
                    state_next = ST_FIN;
                end else begin
                    cmd.calc_ric = 1'b1;
                    state_next   = ST_SB_DIV;
                end
            end
            ST_SB_DIV: begin
                cmd.div_pkts = 1'b1;
                state_next   = ST_SB_DIVW;
            end
            ST_SB_DIVW: begin
                if (!status.div_busy) begin
                    cmd.latch_pcb = 1'b1;
                    cmd.idx_clr   = 1'b1;
                    state_next    = ST_SB_PKT;
                end
            end

            // blast packets then blast-over
            ST_SB_PKT: begin
                if (status.out_free) begin
                    cmd.emit = 1'b1;
                    if (status.idx_lt_pcb) begin
                        cmd.emit_kind = btss_pkg::PK_BLAST;
                        cmd.idx_inc   = 1'b1;
                    end else begin
                        cmd.emit_kind = btss_pkg::PK_BLAST_OVER;
                        cmd.emit_last = 1'b1;
                        phase_next    = PH_WAIT;
                        state_next    = ST_IDLE;
                    end
                end
            end

            // five disconnects
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = btss_pkg::PK_DISCONNECT;
                    cmd.emit_last = status.fin_last;
                    cmd.idx_inc   = 1'b1;
                    if (status.fin_last) begin
                        phase_next = PH_DONE;
                        state_next = ST_IDLE;
                    end
                end
            end

            // resend flagged packets in index order
            ST_RESEND: begin
                if (!status.idx_lt_bound) begin
                    state_next = ST_IDLE;
                end else if (!status.map_bit) begin
                    cmd.idx_inc = 1'b1;
                end else if (status.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = btss_pkg::PK_BLAST;
                    cmd.emit_last = status.map_last;
                    cmd.idx_inc   = 1'b1;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_IDLE;
            hr_reg         <= HR_W'(RETRY_LIMIT);
            rt_reg         <= '0;
            from_start_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            hr_reg         <= hr_next;
            rt_reg         <= rt_next;
            from_start_reg <= from_start_next;
        end
    end
endmodule

// ===== src/blast_transfer_sender_sequencer_top.sv =====
// Blast transfer sender sequencer. Takes one event transaction at a time
// (start, timeout, header ack, missing report, other packet) and returns the
// packet descriptors it causes, the last one flagged by m_last_of_run. An
// event is taken only when the sequencer is back in its idle state; a
// descriptor may still sit in the output register then. A start waits on
// the 33-step serial divider computing the blast count; a header ack with
// new sizing runs that count again; each blast sent makes a second divider
// pass for the packet count, then emits its blast packets and a blast-over;
// a header or report timeout may end in an abort; a resend walks the map
// bits up to the smaller of blast size and 32. Output stalls hold the
// sequencer in its emitting states.
// The user must write the configuration registers with cfg_wr_en only
// while no event is open; the block itself does not enforce this.
// Depends on btss_pkg, btss_ctrl, btss_datapath and btss_div.
module blast_transfer_sender_sequencer_top #(
    parameter int BLAST_PKT_MAX = btss_pkg::BLAST_PKT_MAX_DEF,
    parameter int DEFAULT_RECORDS_PER_PACKET_VALUE = btss_pkg::DEFAULT_RPP_DEF,
    parameter int RETRY_LIMIT = btss_pkg::RETRY_LIMIT_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [btss_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [btss_pkg::CFG_W-1:0]      cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [btss_pkg::KIND_W-1:0]     s_kind,
    input  logic [btss_pkg::STAT_W-1:0]     s_ack_status,
    input  logic [btss_pkg::RPP_W-1:0]      s_ack_records_per_packet,
    input  logic [btss_pkg::APPB_W-1:0]     s_ack_packets_per_blast,
    input  logic [btss_pkg::REC_W-1:0]      s_missing_count,
    input  logic [btss_pkg::MAP_W-1:0]      s_missing_map,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [btss_pkg::KIND_W-1:0]     m_packet_kind,
    output logic [btss_pkg::BLAST_W-1:0]    m_blast_number,
    output logic [btss_pkg::PIDX_W-1:0]     m_packet_index,
    output logic [btss_pkg::PPB_W-1:0]      m_packets_this_blast,
    output logic [btss_pkg::REC_W-1:0]      m_first_record,
    output logic [btss_pkg::RPP_W-1:0]      m_record_count,
    output logic                            m_last_of_run
);
    btss_pkg::ctrl_cmd_t  cmd;
    btss_pkg::dp_status_t status;

    // sequencer
    btss_ctrl #(
        .RETRY_LIMIT(RETRY_LIMIT)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // datapath
    btss_datapath #(
        .BLAST_PKT_MAX(BLAST_PKT_MAX),
        .DEFAULT_RPP(DEFAULT_RECORDS_PER_PACKET_VALUE)
    ) u_dp (
        .aclk                     (aclk),
        .aresetn                  (aresetn),
        .cfg_wr_en                (cfg_wr_en),
        .cfg_index                (cfg_index),
        .cfg_wr_data              (cfg_wr_data),
        .s_kind                   (s_kind),
        .s_ack_status             (s_ack_status),
        .s_ack_records_per_packet (s_ack_records_per_packet),
        .s_ack_packets_per_blast  (s_ack_packets_per_blast),
        .s_missing_count          (s_missing_count),
        .s_missing_map            (s_missing_map),
        .cmd                      (cmd),
        .status                   (status),
        .m_valid                  (m_valid),
        .m_ready                  (m_ready),
        .m_packet_kind            (m_packet_kind),
        .m_blast_number           (m_blast_number),
        .m_packet_index           (m_packet_index),
        .m_packets_this_blast     (m_packets_this_blast),
        .m_first_record           (m_first_record),
        .m_record_count           (m_record_count),
        .m_last_of_run            (m_last_of_run)
    );
endmodule

// ===== tb/testbench.sv =====
// Testbench for blast_transfer_sender_sequencer_top: drives event transactions,
// predicts the packet descriptors with a behavioral sequencer model and checks them.
// Depends on btss_pkg and the sequencer RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int MAX_PPB   = btss_pkg::BLAST_PKT_MAX_DEF;
    localparam int DEF_RPP   = btss_pkg::DEFAULT_RPP_DEF;
    localparam int RETRIES   = btss_pkg::RETRY_LIMIT_DEF;
    localparam int LIMIT_CYC = 2000000;
    localparam int N_RANDOM  = 470;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_HDR, SEQ_WAIT, SEQ_DONE} seq_phase_t;

    typedef struct {
        logic [btss_pkg::KIND_W-1:0] kind;
        logic [btss_pkg::STAT_W-1:0] status;
        logic [btss_pkg::RPP_W-1:0]  arpp;
        logic [btss_pkg::APPB_W-1:0] appb;
        logic [btss_pkg::REC_W-1:0]  mcount;
        logic [btss_pkg::MAP_W-1:0]  mmap;
    } event_t;

    typedef struct {
        logic [btss_pkg::KIND_W-1:0]  kind;
        logic [btss_pkg::BLAST_W-1:0] blast;
        logic [btss_pkg::PIDX_W-1:0]  idx;
        logic [btss_pkg::PPB_W-1:0]   pcount;
        logic [btss_pkg::REC_W-1:0]   first;
        logic [btss_pkg::RPP_W-1:0]   cnt;
        logic                         last;
    } pkt_desc_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [btss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [btss_pkg::CFG_W-1:0] cfg_wr_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [btss_pkg::KIND_W-1:0] s_kind = '0;
    logic [btss_pkg::STAT_W-1:0] s_ack_status = '0;
    logic [btss_pkg::RPP_W-1:0] s_ack_records_per_packet = '0;
    logic [btss_pkg::APPB_W-1:0] s_ack_packets_per_blast = '0;
    logic [btss_pkg::REC_W-1:0] s_missing_count = '0;
    logic [btss_pkg::MAP_W-1:0] s_missing_map = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [btss_pkg::KIND_W-1:0] m_packet_kind;
    logic [btss_pkg::BLAST_W-1:0] m_blast_number;
    logic [btss_pkg::PIDX_W-1:0] m_packet_index;
    logic [btss_pkg::PPB_W-1:0] m_packets_this_blast;
    logic [btss_pkg::REC_W-1:0] m_first_record;
    logic [btss_pkg::RPP_W-1:0] m_record_count;
    logic m_last_of_run;

    blast_transfer_sender_sequencer_top dut (.*);

    // clock
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // sequencer model state and registers
    logic [31:0] reg_total = 32'd1;
    logic [15:0] reg_init_rpp = '0;
    logic [5:0]  reg_init_ppb = '0;
    seq_phase_t  ph = SEQ_IDLE;
    int unsigned hdr_left = RETRIES;
    int unsigned rep_timeouts = 0;
    logic [31:0] cur_blast = 32'd1;
    logic [31:0] rpp_now = '0;
    logic [31:0] ppb_now = '0;
    logic [31:0] rpb_now = '0;
    logic [31:0] blast_total = '0;
    logic [31:0] pkts_cur = '0;
    logic [31:0] recs_cur = '0;

    event_t    pend_q[$];
    pkt_desc_t desc_q[$];
    int        errors = 0;
    bit        calm = 1'b0;

    function automatic void push_desc(logic [2:0] k, logic [31:0] i, logic [31:0] pc,
                                      logic [31:0] f, logic [31:0] c);
        pkt_desc_t d;
        d.kind = k; d.blast = cur_blast; d.idx = i[4:0]; d.pcount = pc[5:0];
        d.first = f; d.cnt = c[15:0]; d.last = 1'b0;
        desc_q.push_back(d);
    endfunction

    function automatic void size_blasts();
        logic [63:0] rpb;
        rpb = 64'(rpp_now) * 64'(ppb_now);
        if (rpb == 0) rpb = 1;
        rpb_now = rpb[31:0];
        blast_total = 32'((64'(reg_total) + rpb - 1) / rpb);
    endfunction

    function automatic logic [63:0] blast_base();
        return 64'(cur_blast - 32'd1) * 64'(rpb_now);
    endfunction

    function automatic void send_disconnects();
        for (int k = 0; k < btss_pkg::FIN_COUNT; k++)
            push_desc(btss_pkg::PK_DISCONNECT, 0, 0, 0, 0);
        ph = SEQ_DONE;
    endfunction

    function automatic void blast_pkt(logic [31:0] i);
        logic [63:0] rpp, loc, left;
        logic [31:0] c;
        rpp = (rpp_now != 0) ? 64'(rpp_now) : 64'd1;
        loc = 64'(i) * rpp;
        c = 0;
        if (loc < 64'(recs_cur)) begin
            left = 64'(recs_cur) - loc;
            c = (left < rpp) ? left[31:0] : rpp[31:0];
        end
        push_desc(btss_pkg::PK_BLAST, i, pkts_cur, 32'(blast_base() + loc), c);
    endfunction

    function automatic void send_blast();
        logic [63:0] base, remain, rpp;
        rpp = (rpp_now != 0) ? 64'(rpp_now) : 64'd1;
        if (cur_blast == 0 || cur_blast > blast_total) begin
            send_disconnects();
            return;
        end
        base = blast_base();
        if (base >= 64'(reg_total)) begin
            send_disconnects();
            return;
        end
        remain = 64'(reg_total) - base;
        recs_cur = (remain > 64'(rpb_now)) ? rpb_now : remain[31:0];
        pkts_cur = 32'(((64'(recs_cur) + rpp - 1) / rpp) & 64'd63);
        for (int i = 0; i < pkts_cur; i++) blast_pkt(i);
        push_desc(btss_pkg::PK_BLAST_OVER, 0, pkts_cur, 0, 0);
        ph = SEQ_WAIT;
    endfunction

    // expected descriptors for one accepted event
    function automatic void predict_event(event_t e);
        int n0;
        n0 = desc_q.size();
        case (ph)
            SEQ_IDLE: if (e.kind == btss_pkg::EV_START) begin
                rpp_now = (reg_init_rpp != 0) ? 32'(reg_init_rpp) : DEF_RPP;
                ppb_now = (reg_init_ppb != 0) ? 32'(reg_init_ppb) : MAX_PPB;
                if (ppb_now > MAX_PPB) ppb_now = MAX_PPB;
                size_blasts();
                hdr_left = RETRIES;
                push_desc(btss_pkg::PK_HEADER, 0, 0, 0, 0);
                ph = SEQ_HDR;
            end
            SEQ_HDR: if (e.kind == btss_pkg::EV_TIMEOUT) begin
                if (hdr_left > 0) hdr_left--;
                push_desc(btss_pkg::PK_HEADER, 0, 0, 0, 0);
                if (hdr_left == 0) begin
                    push_desc(btss_pkg::PK_ABORT, 0, 0, 0, 0);
                    ph = SEQ_DONE;
                end
            end else if (e.kind == btss_pkg::EV_HDR_ACK) begin
                if (e.status != 0) begin
                    if (e.arpp > 0) rpp_now = e.arpp;
                    if (e.appb > 0) ppb_now = (e.appb > MAX_PPB) ? MAX_PPB : e.appb;
                    size_blasts();
                end
                rep_timeouts = 0;
                send_blast();
            end
            SEQ_WAIT: if (e.kind == btss_pkg::EV_TIMEOUT) begin
                rep_timeouts++;
                if (rep_timeouts > RETRIES) begin
                    push_desc(btss_pkg::PK_ABORT, 0, 0, 0, 0);
                    ph = SEQ_DONE;
                end else begin
                    push_desc(btss_pkg::PK_BLAST_OVER, 0, pkts_cur, 0, 0);
                end
            end else if (e.kind == btss_pkg::EV_HDR_ACK || e.kind == btss_pkg::EV_MISSING
                         || e.kind == btss_pkg::EV_OTHER) begin
                rep_timeouts = 0;
                if (e.kind == btss_pkg::EV_MISSING) begin
                    if (e.mcount == 0) begin
                        if (cur_blast >= blast_total) send_disconnects();
                        else begin
                            cur_blast++;
                            send_blast();
                        end
                    end else begin
                        for (int i = 0; i < ppb_now && i < 32; i++)
                            if (e.mmap[i]) blast_pkt(i);
                    end
                end
            end
            default: ;
        endcase
        if (desc_q.size() > n0) desc_q[$].last = 1'b1;
    endfunction

    // driver: event transactions with random idle bursts
    int gap_cnt = 0;
    event_t cur_ev;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // hold the pending transaction
        end else begin
            if (s_valid) predict_event(cur_ev);
            if (gap_cnt > 0) begin
                gap_cnt--;
                s_valid <= 1'b0;
            end else if (pend_q.size() == 0) begin
                s_valid <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                gap_cnt = $urandom_range(0, 4);
                s_valid <= 1'b0;
            end else begin
                cur_ev = pend_q.pop_front();
                s_valid <= 1'b1;
                s_kind <= cur_ev.kind;
                s_ack_status <= cur_ev.status;
                s_ack_records_per_packet <= cur_ev.arpp;
                s_ack_packets_per_blast <= cur_ev.appb;
                s_missing_count <= cur_ev.mcount;
                s_missing_map <= cur_ev.mmap;
            end
        end
    end

    // monitor: compare descriptors, stall the result side in bursts
    int stall_cnt = 0;
    always @(posedge aclk) begin
        pkt_desc_t d;
        if (aresetn && m_valid && m_ready) begin
            if (desc_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected descriptor kind %0d", m_packet_kind);
            end else begin
                d = desc_q.pop_front();
                if (m_packet_kind !== d.kind || m_blast_number !== d.blast
                    || m_packet_index !== d.idx || m_packets_this_blast !== d.pcount
                    || m_first_record !== d.first || m_record_count !== d.cnt
                    || m_last_of_run !== d.last) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch exp k%0d b%0d i%0d p%0d f%0d c%0d l%0d",
                                  " got k%0d b%0d i%0d p%0d f%0d c%0d l%0d"},
                                 d.kind, d.blast, d.idx, d.pcount, d.first, d.cnt, d.last,
                                 m_packet_kind, m_blast_number, m_packet_index,
                                 m_packets_this_blast, m_first_record, m_record_count,
                                 m_last_of_run);
                end
            end
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_cnt > 0) begin
            stall_cnt--;
            m_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 5) == 0) begin
            stall_cnt = $urandom_range(0, 4);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // run limit
    int cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > LIMIT_CYC) begin
            $display("** blast_transfer_sender_sequencer_top: FAILED **");
            $finish;
        end
    end

    function automatic void add_event(logic [2:0] k, logic [7:0] st, logic [15:0] arpp,
                                      logic [15:0] appb, logic [31:0] mc, logic [31:0] mm);
        event_t e;
        e.kind = k; e.status = st; e.arpp = arpp; e.appb = appb; e.mcount = mc; e.mmap = mm;
        pend_q.push_back(e);
    endfunction

    task automatic drain();
        while (pend_q.size() != 0 || s_valid || desc_q.size() != 0) @(posedge aclk);
        repeat (100) @(posedge aclk);
    endtask

    task automatic write_reg(logic [btss_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        case (idx)
            btss_pkg::CFG_TOTAL_RECORDS: reg_total = val;
            btss_pkg::CFG_INIT_RPP:      reg_init_rpp = val[15:0];
            btss_pkg::CFG_INIT_PPB:      reg_init_ppb = val[5:0];
            default: ;
        endcase
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    // partial blast coming next: a short tail after the current blast
    task automatic set_short_next(int unsigned extra);
        write_reg(btss_pkg::CFG_TOTAL_RECORDS, cur_blast * rpb_now + extra);
    endtask

    function automatic void random_events(int count);
        int tmo_run;
        int sel;
        logic [2:0] k;
        logic [31:0] mc;
        tmo_run = 0;
        for (int n = 0; n < count; n++) begin
            sel = $urandom_range(0, 99);
            mc = $urandom;
            if (mc == 0) mc = 32'hFFFF_FFFF;
            if (sel < 55) k = btss_pkg::EV_MISSING;
            else if (sel < 67) begin k = btss_pkg::EV_MISSING; mc = 0; end
            else if (sel < 80 && tmo_run < RETRIES) k = btss_pkg::EV_TIMEOUT;
            else if (sel < 88) k = btss_pkg::EV_OTHER;
            else if (sel < 95) k = btss_pkg::EV_HDR_ACK;
            else k = (sel < 97) ? btss_pkg::EV_START : 3'($urandom_range(5, 7));
            if (k == btss_pkg::EV_TIMEOUT) tmo_run++;
            else if (k == btss_pkg::EV_HDR_ACK || k == btss_pkg::EV_MISSING
                     || k == btss_pkg::EV_OTHER) tmo_run = 0;
            add_event(k, $urandom, $urandom, $urandom, mc, $urandom);
        end
    endfunction

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // register extremes, then a huge file
        write_reg(btss_pkg::CFG_TOTAL_RECORDS, 32'd1);
        write_reg(btss_pkg::CFG_INIT_RPP, 32'hFFFF);
        write_reg(btss_pkg::CFG_INIT_RPP, 32'd0);
        write_reg(btss_pkg::CFG_INIT_PPB, 32'd63);
        write_reg(btss_pkg::CFG_TOTAL_RECORDS, 32'hFFFF_FFFF);

        // directed: ignored in idle, header retries, sizing from the ack
        add_event(btss_pkg::EV_TIMEOUT, 8'h00, 16'h0, 16'h0, 32'h0, 32'h0);
        add_event(btss_pkg::EV_MISSING, 8'hFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF,
                  32'hFFFF_FFFF);
        add_event(btss_pkg::EV_START, 8'h00, 16'h0, 16'h0, 32'h0, 32'h0);
        add_event(btss_pkg::EV_START, 8'h00, 16'h0, 16'h0, 32'h0, 32'h0);
        repeat (3) add_event(btss_pkg::EV_TIMEOUT, 8'h00, 16'h0, 16'h0, 32'h0, 32'h0);
        add_event(btss_pkg::EV_OTHER, 8'h00, 16'h0, 16'h0, 32'h0, 32'h0);
        add_event(btss_pkg::EV_HDR_ACK, 8'h80, 16'h0, 16'd20, 32'h0, 32'h0);
        // in the report wait: resends, masked map bits, timeouts below abort
        add_event(btss_pkg::EV_START, 8'h00, 16'h0, 16'h0, 32'h0, 32'h0);
        add_event(btss_pkg::EV_MISSING, 8'h00, 16'h0, 16'h0, 32'd1, 32'hFFFF_FFFF);
        add_event(btss_pkg::EV_MISSING, 8'h00, 16'h0, 16'h0, 32'd5, 32'h0);
        add_event(btss_pkg::EV_MISSING, 8'h00, 16'h0, 16'h0, 32'd1, 32'hFFF0_0000);
        repeat (5) add_event(btss_pkg::EV_TIMEOUT, 8'h00, 16'h0, 16'h0, 32'h0, 32'h0);
        add_event(btss_pkg::EV_OTHER, 8'h00, 16'h0, 16'h0, 32'h0, 32'h0);
        add_event(btss_pkg::EV_TIMEOUT, 8'h00, 16'h0, 16'h0, 32'h0, 32'h0);
        add_event(btss_pkg::EV_MISSING, 8'h00, 16'h0, 16'h0, 32'h0, 32'h0);
        add_event(btss_pkg::EV_HDR_ACK, 8'hFF, 16'hFFFF, 16'hFFFF, 32'h0, 32'h0);
        drain();

        // short last blast with empty packets past its end
        set_short_next(50);
        add_event(btss_pkg::EV_MISSING, 8'h00, 16'h0, 16'h0, 32'h0, 32'h0);
        add_event(btss_pkg::EV_MISSING, 8'h00, 16'h0, 16'h0, 32'h2, 32'hFFFF_FFFF);
        drain();
        write_reg(btss_pkg::CFG_TOTAL_RECORDS, 32'hFFFF_FFFF);

        // random traffic, a short blast in the middle
        random_events(N_RANDOM / 2);
        drain();
        set_short_next($urandom_range(1, 319));
        add_event(btss_pkg::EV_MISSING, 8'h00, 16'h0, 16'h0, 32'h0, 32'h0);
        add_event(btss_pkg::EV_MISSING, 8'h00, 16'h0, 16'h0, 32'h1, $urandom);
        drain();
        write_reg(btss_pkg::CFG_TOTAL_RECORDS, 32'hFFFF_FFFF);
        random_events(N_RANDOM / 2 - 60);
        drain();
        calm = 1'b1;
        random_events(60);
        drain();

        // end of file right after the current blast, then disconnects
        write_reg(btss_pkg::CFG_TOTAL_RECORDS, cur_blast * rpb_now);
        add_event(btss_pkg::EV_MISSING, 8'h00, 16'h0, 16'h0, 32'h0, 32'h0);
        add_event(btss_pkg::EV_TIMEOUT, 8'h00, 16'h0, 16'h0, 32'h0, 32'h0);
        add_event(btss_pkg::EV_START, 8'h00, 16'h0, 16'h0, 32'h0, 32'h0);
        drain();

        if (errors == 0 && desc_q.size() == 0)
            $display("** blast_transfer_sender_sequencer_top: PASSED **");
        else
            $display("** blast_transfer_sender_sequencer_top: FAILED **");
        $finish;
    end

endmodule
